@@ design/lbp_pkg.sv @@
package lbp_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int PIXEL_BITS = 8;
	localparam int MAX_HEIGHT = 4096;
	localparam int MIN_DIM    = 3;

	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int ROW_W   = 12;
	localparam int IWD_W   = 11;
	localparam int HGT_W   = 13;
	localparam int WU_W    = (COL_W + 1 > IWD_W) ? COL_W + 1 : IWD_W;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
	localparam logic [1:0] REG_SIGNED_PIXELS = 2'd2;

	localparam logic [IWD_W-1:0] RST_IMAGE_WIDTH  = IWD_W'(640);
	localparam logic [HGT_W-1:0] RST_IMAGE_HEIGHT = HGT_W'(480);

	typedef logic [PIXEL_BITS-1:0] pix_t;

	typedef struct packed {
		logic [WU_W-1:0]  width_use;
		logic [HGT_W-1:0] height_use;
		logic             signed_pixels;
	} cfg_t;

	typedef struct packed {
		logic             has_res;
		logic             last_col;
		logic             last_row;
		logic [COL_W-1:0] col;
		pix_t             pixel;
	} s1_t;

	// neighbour strictly greater than centre; signed order by flipping the sign bit
	function automatic logic gt(input pix_t nb, input pix_t c, input logic sgn);
		pix_t sm;
		sm = {sgn, {(PIXEL_BITS-1){1'b0}}};
		return (nb ^ sm) > (c ^ sm);
	endfunction

endpackage

@@ design/lbp_ram.sv @@
module lbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ design/lbp_regs.sv @@
module lbp_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lbp_pkg::PADDR_W-1:0]   paddr,
	input  logic [lbp_pkg::PDATA_W-1:0]   pwdata,
	output logic [lbp_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output lbp_pkg::cfg_t                 cfg
);

	logic [lbp_pkg::IWD_W-1:0] width_q;
	logic [lbp_pkg::HGT_W-1:0] height_q;
	logic                      signed_q;
	logic                      wr_en;
	logic [1:0]                reg_sel;
	logic [lbp_pkg::WU_W-1:0]  width_ext;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= lbp_pkg::RST_IMAGE_WIDTH;
			height_q <= lbp_pkg::RST_IMAGE_HEIGHT;
			signed_q <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_sel)
				lbp_pkg::REG_IMAGE_WIDTH:   width_q  <= pwdata[lbp_pkg::IWD_W-1:0];
				lbp_pkg::REG_IMAGE_HEIGHT:  height_q <= pwdata[lbp_pkg::HGT_W-1:0];
				lbp_pkg::REG_SIGNED_PIXELS: signed_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			lbp_pkg::REG_IMAGE_WIDTH:   prdata = lbp_pkg::PDATA_W'(width_q);
			lbp_pkg::REG_IMAGE_HEIGHT:  prdata = lbp_pkg::PDATA_W'(height_q);
			lbp_pkg::REG_SIGNED_PIXELS: prdata = lbp_pkg::PDATA_W'(signed_q);
			default:                    prdata = '0;
		endcase
	end

	// dimensions in use, saturated to the supported range
	assign width_ext = lbp_pkg::WU_W'(width_q);

	always_comb begin
		if (width_ext < lbp_pkg::WU_W'(lbp_pkg::MIN_DIM)) begin
			cfg.width_use = lbp_pkg::WU_W'(lbp_pkg::MIN_DIM);
		end else if (width_ext > lbp_pkg::WU_W'(lbp_pkg::MAX_WIDTH)) begin
			cfg.width_use = lbp_pkg::WU_W'(lbp_pkg::MAX_WIDTH);
		end else begin
			cfg.width_use = width_ext;
		end
		if (height_q < lbp_pkg::HGT_W'(lbp_pkg::MIN_DIM)) begin
			cfg.height_use = lbp_pkg::HGT_W'(lbp_pkg::MIN_DIM);
		end else if (height_q > lbp_pkg::HGT_W'(lbp_pkg::MAX_HEIGHT)) begin
			cfg.height_use = lbp_pkg::HGT_W'(lbp_pkg::MAX_HEIGHT);
		end else begin
			cfg.height_use = height_q;
		end
		cfg.signed_pixels = signed_q;
	end

endmodule

@@ design/lbp_kernel.sv @@
module lbp_kernel (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  lbp_pkg::pix_t pixel,
	input  lbp_pkg::pix_t top,
	input  lbp_pkg::pix_t mid,
	input  logic          sgn,
	output logic [7:0]    code
);

	// [0],[1] top row c-2,c-1; [2],[3] middle row; [4],[5] bottom row
	lbp_pkg::pix_t win_q [6];
	lbp_pkg::pix_t ctr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (advance) begin
			win_q[0] <= win_q[1];
			win_q[1] <= top;
			win_q[2] <= win_q[3];
			win_q[3] <= mid;
			win_q[4] <= win_q[5];
			win_q[5] <= pixel;
		end
	end

	assign ctr = win_q[3];

	assign code = {
		lbp_pkg::gt(win_q[0], ctr, sgn),
		lbp_pkg::gt(win_q[1], ctr, sgn),
		lbp_pkg::gt(top,      ctr, sgn),
		lbp_pkg::gt(mid,      ctr, sgn),
		lbp_pkg::gt(pixel,    ctr, sgn),
		lbp_pkg::gt(win_q[5], ctr, sgn),
		lbp_pkg::gt(win_q[4], ctr, sgn),
		lbp_pkg::gt(win_q[2], ctr, sgn)
	};

endmodule

@@ design/lbp_3x3_code_stream.sv @@
// channel   direction  handshake                  payload
// pixel     in         pixel_valid / pixel_ready  pixel
// code      out        code_valid / code_ready    lbp_code, end_of_row, end_of_frame
// config    in         APB psel/penable/pready    paddr, pwdata, prdata
//
// One pixel per clock sustained unless the output stalls; a code passes the beat_s1
// and output registers. Rate is set by the single read port of each line buffer RAM.
// Reset clears counters, window and valid flags; line buffers are not cleared.
// A stalled code holds the kernel stage; pixels keep flowing while the stage can drain.
module lbp_3x3_code_stream (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lbp_pkg::PADDR_W-1:0] paddr,
	input  logic [lbp_pkg::PDATA_W-1:0] pwdata,
	output logic [lbp_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        pixel_valid,
	output logic                        pixel_ready,
	input  lbp_pkg::pix_t               pixel,
	output logic                        code_valid,
	input  logic                        code_ready,
	output logic [7:0]                  lbp_code,
	output logic                        end_of_row,
	output logic                        end_of_frame
);

	lbp_pkg::cfg_t             cfg;
	logic [lbp_pkg::COL_W-1:0] col_q;
	logic [lbp_pkg::ROW_W-1:0] row_q;
	logic [lbp_pkg::WU_W-1:0]  col_nx;
	logic [lbp_pkg::HGT_W-1:0] row_nx;
	logic                      last_col;
	logic                      last_row;
	logic                      in_fire;
	logic                      s1_fire;
	logic                      out_free;
	logic                      valid_s1;
	lbp_pkg::s1_t              beat_s1;
	lbp_pkg::pix_t             top_rd;
	lbp_pkg::pix_t             mid_rd;
	logic [7:0]                code;
	logic                      code_valid_q;
	logic [7:0]                code_q;
	logic                      eor_q;
	logic                      eof_q;

	lbp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign col_nx   = lbp_pkg::WU_W'(col_q) + lbp_pkg::WU_W'(1);
	assign row_nx   = lbp_pkg::HGT_W'(row_q) + lbp_pkg::HGT_W'(1);
	assign last_col = col_nx >= cfg.width_use;
	assign last_row = row_nx >= cfg.height_use;

	assign out_free    = !code_valid_q || code_ready;
	assign s1_fire     = valid_s1 && (!beat_s1.has_res || out_free);
	assign pixel_ready = !valid_s1 || s1_fire;
	assign in_fire     = pixel_valid && pixel_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_fire) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : lbp_pkg::ROW_W'(row_nx);
			end else begin
				col_q <= lbp_pkg::COL_W'(col_nx);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			beat_s1.has_res  <= (row_q >= lbp_pkg::ROW_W'(2)) && (col_q >= lbp_pkg::COL_W'(2));
			beat_s1.last_col <= last_col;
			beat_s1.last_row <= last_row;
			beat_s1.col      <= col_q;
			beat_s1.pixel    <= pixel;
		end
	end

	lbp_ram #(
		.WIDTH (lbp_pkg::PIXEL_BITS),
		.DEPTH (lbp_pkg::MAX_WIDTH)
	) u_line_upper (
		.clk   (clk),
		.we    (s1_fire),
		.waddr (beat_s1.col),
		.wdata (mid_rd),
		.re    (in_fire),
		.raddr (col_q),
		.rdata (top_rd)
	);

	lbp_ram #(
		.WIDTH (lbp_pkg::PIXEL_BITS),
		.DEPTH (lbp_pkg::MAX_WIDTH)
	) u_line_middle (
		.clk   (clk),
		.we    (s1_fire),
		.waddr (beat_s1.col),
		.wdata (beat_s1.pixel),
		.re    (in_fire),
		.raddr (col_q),
		.rdata (mid_rd)
	);

	lbp_kernel u_kernel (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (s1_fire),
		.pixel   (beat_s1.pixel),
		.top     (top_rd),
		.mid     (mid_rd),
		.sgn     (cfg.signed_pixels),
		.code    (code)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_valid_q <= 1'b0;
		end else if (s1_fire && beat_s1.has_res) begin
			code_valid_q <= 1'b1;
		end else if (code_ready) begin
			code_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && beat_s1.has_res) begin
			code_q <= code;
			eor_q  <= beat_s1.last_col;
			eof_q  <= beat_s1.last_col && beat_s1.last_row;
		end
	end

	assign code_valid   = code_valid_q;
	assign lbp_code     = code_q;
	assign end_of_row   = eor_q;
	assign end_of_frame = eof_q;

`ifndef SYNTHESIS
	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && last_col && last_row) |=> (col_q == '0 && row_q == '0))
		else $error("counters did not wrap at frame end");

	a_rd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_fire) |=> ($stable(top_rd) && $stable(mid_rd)))
		else $error("line buffer data changed under a stalled beat");

	a_eof_eor: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid_q |-> (!eof_q || eor_q))
		else $error("frame end without row end");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!pixel_ready |-> (valid_s1 && beat_s1.has_res && code_valid_q && !code_ready))
		else $error("pixel input stalled without a blocked result");
`endif

endmodule

@@ tb/tb.sv @@
module tb;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_SHARE = 100;

	typedef struct packed {
		logic [7:0] code;
		logic       row_end;
		logic       frame_end;
	} lbp_result_t;

	// tracks the 3x3 window and line stores, queues the codes they produce
	class lbp_code_tracker;
		logic [7:0]  upper_line [lbp_pkg::MAX_WIDTH];
		logic [7:0]  middle_line [lbp_pkg::MAX_WIDTH];
		logic [7:0]  win [6];
		int unsigned col;
		int unsigned row;
		int unsigned width_reg;
		int unsigned height_reg;
		bit          signed_mode;
		lbp_result_t codes_due [$];
		int          errors;

		function new();
			for (int i = 0; i < lbp_pkg::MAX_WIDTH; i++) begin
				upper_line[i]  = '0;
				middle_line[i] = '0;
			end
			foreach (win[i]) win[i] = '0;
			col         = 0;
			row         = 0;
			width_reg   = 32'(lbp_pkg::RST_IMAGE_WIDTH);
			height_reg  = 32'(lbp_pkg::RST_IMAGE_HEIGHT);
			signed_mode = 1'b0;
			errors      = 0;
		endfunction

		function void write_reg(input logic [1:0] idx, input logic [31:0] v);
			case (idx)
				lbp_pkg::REG_IMAGE_WIDTH:   width_reg   = 32'(v[lbp_pkg::IWD_W-1:0]);
				lbp_pkg::REG_IMAGE_HEIGHT:  height_reg  = 32'(v[lbp_pkg::HGT_W-1:0]);
				lbp_pkg::REG_SIGNED_PIXELS: signed_mode = v[0];
				default: ;
			endcase
		endfunction

		function int unsigned clamp(input int unsigned v, input int unsigned hi);
			if (v < lbp_pkg::MIN_DIM) return lbp_pkg::MIN_DIM;
			if (v > hi) return hi;
			return v;
		endfunction

		function bit above(input logic [7:0] nb, input logic [7:0] ctr);
			if (signed_mode) return $signed(nb) > $signed(ctr);
			return nb > ctr;
		endfunction

		function int pending();
			return codes_due.size();
		endfunction

		function void note_pixel(input lbp_pkg::pix_t p);
			int unsigned w;
			int unsigned h;
			int unsigned idx;
			logic [7:0]  top;
			logic [7:0]  mid;
			logic [7:0]  ctr;
			bit          last_col;
			bit          last_row;
			lbp_result_t r;
			w        = clamp(width_reg, lbp_pkg::MAX_WIDTH);
			h        = clamp(height_reg, lbp_pkg::MAX_HEIGHT);
			idx      = col % lbp_pkg::MAX_WIDTH;
			top      = upper_line[idx];
			mid      = middle_line[idx];
			last_col = (col + 1 >= w);
			last_row = (row + 1 >= h);
			if (row >= 2 && col >= 2) begin
				ctr = win[3];
				r.code = {above(win[0], ctr), above(win[1], ctr), above(top, ctr),
					above(mid, ctr), above(p, ctr), above(win[5], ctr),
					above(win[4], ctr), above(win[2], ctr)};
				r.row_end   = last_col;
				r.frame_end = last_col && last_row;
				codes_due.push_back(r);
			end
			win[0] = win[1];
			win[1] = top;
			win[2] = win[3];
			win[3] = mid;
			win[4] = win[5];
			win[5] = p;
			upper_line[idx]  = mid;
			middle_line[idx] = p;
			if (last_col) begin
				col = 0;
				row = last_row ? 0 : row + 1;
			end else begin
				col = col + 1;
			end
		endfunction

		task report(input string msg);
			$display("[%0t] lbp check: %s", $time, msg);
			errors++;
		endtask

		task check_code(input logic [7:0] code, input logic eor, input logic eof);
			lbp_result_t r;
			if (codes_due.size() == 0) begin
				report($sformatf("code %02h with none expected", code));
				return;
			end
			r = codes_due.pop_front();
			if (code !== r.code)
				report($sformatf("lbp_code %02h, want %02h", code, r.code));
			if (eor !== r.row_end)
				report($sformatf("end_of_row %b, want %b", eor, r.row_end));
			if (eof !== r.frame_end)
				report($sformatf("end_of_frame %b, want %b", eof, r.frame_end));
		endtask
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [lbp_pkg::PADDR_W-1:0]   paddr;
	logic [lbp_pkg::PDATA_W-1:0]   pwdata;
	logic [lbp_pkg::PDATA_W-1:0]   prdata;
	logic                          pready;
	logic                          pixel_valid;
	logic                          pixel_ready;
	lbp_pkg::pix_t                 pixel;
	logic                          code_valid;
	logic                          code_ready;
	logic [7:0]                    lbp_code;
	logic                          end_of_row;
	logic                          end_of_frame;

	lbp_code_tracker sb;
	int              send_idle_pct;
	int              recv_idle_pct;
	int              code_hold;
	int              pixels_sent;
	int unsigned     cycles;

	lbp_3x3_code_stream u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.pixel        (pixel),
		.code_valid   (code_valid),
		.code_ready   (code_ready),
		.lbp_code     (lbp_code),
		.end_of_row   (end_of_row),
		.end_of_frame (end_of_frame)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// code sink; a nonzero hold keeps ready low while it counts down to zero
	always @(posedge clk) begin
		if (code_hold > 0) begin
			code_hold = code_hold - 1;
			code_ready <= 1'b0;
		end else begin
			code_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (code_valid === 1'b1 && code_ready === 1'b1)
			sb.check_code(lbp_code, end_of_row, end_of_frame);
	end

	task send_pixel(input lbp_pkg::pix_t p);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < send_idle_pct) gap++;
		if (gap > 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel       <= p;
		pixel_valid <= 1'b1;
		@(posedge clk);
		while (pixel_ready !== 1'b1) @(posedge clk);
		sb.note_pixel(p);
		pixels_sent++;
	endtask

	task apb_write(input logic [1:0] idx, input logic [31:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= lbp_pkg::PADDR_W'({idx, 2'b00});
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1) @(posedge clk);
		sb.write_reg(idx, v);
	endtask

	// registers change only with the pipeline drained
	task configure(input int unsigned w_reg, input int unsigned h_reg, input bit sgn);
		pixel_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		apb_write(lbp_pkg::REG_IMAGE_WIDTH, w_reg);
		apb_write(lbp_pkg::REG_IMAGE_HEIGHT, h_reg);
		apb_write(lbp_pkg::REG_SIGNED_PIXELS, 32'(sgn));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic lbp_pkg::pix_t pick_pixel(input int style, input lbp_pkg::pix_t base);
		case (style)
			0: return lbp_pkg::pix_t'($urandom);
			1: return base + lbp_pkg::pix_t'($urandom_range(0, 4)) - 8'd2;
			2: begin
				case ($urandom_range(0, 3))
					0: return 8'h00;
					1: return 8'h7f;
					2: return 8'h80;
					default: return 8'hff;
				endcase
			end
			default: return base ^ {$urandom_range(0, 1) == 1, 6'd0, $urandom_range(0, 1) == 1};
		endcase
	endfunction

	task run_frame(input int unsigned w_reg, input int unsigned h_reg, input bit sgn,
			input int hold);
		int            style;
		lbp_pkg::pix_t base;
		configure(w_reg, h_reg, sgn);
		code_hold = hold;
		style = $urandom_range(0, 3);
		base  = lbp_pkg::pix_t'($urandom);
		do begin
			send_pixel(pick_pixel(style, base));
		end while (sb.col != 0 || sb.row != 0);
	endtask

	task random_frames();
		int          start;
		int unsigned w_reg;
		int unsigned h_reg;
		start = pixels_sent;
		while (pixels_sent - start < RANDOM_SHARE) begin
			w_reg = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
			h_reg = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
			run_frame(w_reg, h_reg, $urandom_range(0, 1), 0);
		end
	endtask

	initial begin
		lbp_pkg::pix_t probe [9];
		probe = '{8'h81, 8'h80, 8'h7f, 8'h7f, 8'h80, 8'hff, 8'h80, 8'h81, 8'h00};
		clk           = 1'b0;
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		pixel_valid   = 1'b0;
		pixel         = '0;
		code_ready    = 1'b0;
		code_hold     = 0;
		pixels_sent   = 0;
		cycles        = 0;
		send_idle_pct = 37;
		recv_idle_pct = 54;
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single 3x3 frame: ties, greater and smaller neighbours around 0x80
		configure(3, 3, 1'b0);
		foreach (probe[i]) send_pixel(probe[i]);

		// mid-frame change: column and row counts already past the new limits
		configure(5, 8191, 1'b1);
		repeat (18) send_pixel(lbp_pkg::pix_t'($urandom));
		configure(0, 2, 1'b1);
		send_pixel(lbp_pkg::pix_t'($urandom));

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 37;
					recv_idle_pct = 54;
					run_frame(12, 0, 1'b0, 0);
				end
				1: begin
					send_idle_pct = 54;
					recv_idle_pct = 37;
					run_frame(1, 7, 1'b1, 0);
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					// long hold reaches into the coded rows and backs up the input
					run_frame(20, 3, 1'b1, 120);
					run_frame(3, 9, 1'b0, 0);
				end
			endcase
			random_frames();
		end

		pixel_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (2 * DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

@@ files.f @@
design/lbp_pkg.sv
design/lbp_ram.sv
design/lbp_regs.sv
design/lbp_kernel.sv
design/lbp_3x3_code_stream.sv
tb/tb.sv
